// File: src/bpc_pkg.sv
// Shared types, state codes and helper functions for the pressure
// compensation core. No dependencies.
`default_nettype none
package bpc_pkg;

	localparam int unsigned NumRegs = 8;
	localparam int unsigned CfgIdxW = 8;
	localparam int unsigned WordW = 64;
	localparam int unsigned StepW = 5;

	// Register indexes.
	localparam logic [CfgIdxW-1:0] RegT1 = 8'd0;
	localparam logic [CfgIdxW-1:0] RegT2 = 8'd1;
	localparam logic [CfgIdxW-1:0] RegT3 = 8'd2;
	localparam logic [CfgIdxW-1:0] RegP1 = 8'd3;
	localparam logic [CfgIdxW-1:0] RegP23 = 8'd4;
	localparam logic [CfgIdxW-1:0] RegP45 = 8'd5;
	localparam logic [CfgIdxW-1:0] RegP67 = 8'd6;
	localparam logic [CfgIdxW-1:0] RegP89 = 8'd7;

	localparam logic OpTemp = 1'b0;
	localparam logic OpPress = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CALC = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_OUT  = 5'b10000
	} seq_state_t;

	typedef struct packed {
		logic              start;
		logic [WordW-1:0]  a;
		logic [WordW-1:0]  b;
	} op_req_t;

	function automatic logic [63:0] sx16(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	function automatic logic [63:0] sx32(input logic [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

endpackage
`default_nettype wire

// File: src/baro_temp_pressure_compensation_core.sv
// Temperature and pressure compensation core with a step sequencer over a
// bit-serial multiplier and a bit-serial divider. Depends on bpc_pkg, bpc_mul
// and bpc_div. A temperature item runs four multiplies; a pressure item runs
// ten multiplies and one divide, and stops early, before the divide, when the
// divisor is zero. One item at a time; the next is taken in the cycle after
// the result is registered. Reset clears the calibration registers, the
// sequencer and the fine temperature.
`default_nettype none
module baro_temp_pressure_compensation_core
	import bpc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                opcode,
	input  wire logic [19:0]         raw_sample,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     result_kind,
	output logic signed [31:0]       temperature_centi,
	output logic [31:0]              pressure_q24_8,
	output logic                     zero_divisor,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [31:0]         cfg_data
);
	logic [31:0]      cal_q [NumRegs];
	logic [31:0]      fine_q;
	seq_state_t       state_q;
	logic [StepW-1:0] step_q;
	logic             kind_q;
	logic [19:0]      adc_q;
	logic [WordW-1:0] r0_q, r1_q, r2_q;
	op_req_t          mul_req_q, div_req_q;
	logic             mul_done, div_done;
	logic [WordW-1:0] mp, dq;
	logic [31:0]      res_temp_q, res_press_q;
	logic             res_zero_q;
	logic             out_valid_q, out_kind_q, out_zero_q;
	logic [31:0]      out_temp_q, out_press_q;

	logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic [31:0] ta, tb, tv2, tft, tres;
	logic [63:0] pv1, pden, pnum, pq13;

	bpc_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mul_req_q), .done(mul_done), .prod(mp));
	bpc_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req_q), .done(div_done), .quo(dq));

	always_comb begin
		t1 = {48'b0, cal_q[3'(RegT1)][15:0]};
		t2 = sx16(cal_q[3'(RegT2)][15:0]);
		t3 = sx16(cal_q[3'(RegT3)][15:0]);
		p1 = {48'b0, cal_q[3'(RegP1)][15:0]};
		p2 = sx16(cal_q[3'(RegP23)][15:0]);
		p3 = sx16(cal_q[3'(RegP23)][31:16]);
		p4 = sx16(cal_q[3'(RegP45)][15:0]);
		p5 = sx16(cal_q[3'(RegP45)][31:16]);
		p6 = sx16(cal_q[3'(RegP67)][15:0]);
		p7 = sx16(cal_q[3'(RegP67)][31:16]);
		p8 = sx16(cal_q[3'(RegP89)][15:0]);
		p9 = sx16(cal_q[3'(RegP89)][31:16]);
		ta   = 32'(adc_q >> 3) - {t1[30:0], 1'b0};
		tb   = 32'(adc_q >> 4) - t1[31:0];
		tv2  = 32'($signed(mp[31:0]) >>> 14);
		tft  = r0_q[31:0] + tv2;
		tres = 32'($signed(mp[31:0] + 32'd128) >>> 8);
		pv1  = 64'($signed(mp) >>> 33);
		pden = sx32(fine_q) - 64'd128000;
		pnum = ({44'b0, 20'(21'd1048576 - {1'b0, adc_q})} << 31) - r2_q;
		if (adc_q == 20'd0) begin
			pnum = (64'd1048576 << 31) - r2_q;
		end
		pq13 = 64'($signed(dq) >>> 13);
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumRegs; i++) begin
				cal_q[i] <= '0;
			end
		end else if (cfg_valid && (cfg_index < CfgIdxW'(NumRegs))) begin
			if (cfg_index <= RegP1) begin
				cal_q[cfg_index[2:0]] <= {16'b0, cfg_data[15:0]};
			end else begin
				cal_q[cfg_index[2:0]] <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			fine_q      <= '0;
			out_valid_q <= 1'b0;
			mul_req_q   <= '0;
			div_req_q   <= '0;
		end else begin
			mul_req_q.start <= 1'b0;
			div_req_q.start <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CALC;
						step_q  <= '0;
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						state_q <= ST_CALC;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_CALC;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_CALC: begin
					step_q <= step_q + StepW'(1);
					if (kind_q == OpTemp) begin
						case (step_q)
							5'd0: begin
								mul_req_q <= '{1'b1, sx32(ta), t2};
								state_q   <= ST_MUL;
							end
							5'd1: begin
								mul_req_q <= '{1'b1, sx32(tb), sx32(tb)};
								state_q   <= ST_MUL;
							end
							5'd2: begin
								mul_req_q <= '{1'b1, sx32(32'($signed(mp[31:0]) >>> 12)), t3};
								state_q   <= ST_MUL;
							end
							5'd3: begin
								fine_q    <= tft;
								mul_req_q <= '{1'b1, sx32(tft), 64'd5};
								state_q   <= ST_MUL;
							end
							default: begin
								state_q <= ST_OUT;
							end
						endcase
					end else begin
						case (step_q)
							5'd0, 5'd1, 5'd2, 5'd4, 5'd5, 5'd7, 5'd10, 5'd11, 5'd12: begin
								state_q <= ST_MUL;
								case (step_q)
									5'd0: mul_req_q <= '{1'b1, pden, pden};
									5'd1: mul_req_q <= '{1'b1, mp, p6};
									5'd2: mul_req_q <= '{1'b1, r0_q, p5};
									5'd4: mul_req_q <= '{1'b1, r1_q, p3};
									5'd5: mul_req_q <= '{1'b1, r0_q, p2};
									5'd7: mul_req_q <= '{1'b1, r1_q + (64'd1 << 47), p1};
									5'd10: mul_req_q <= '{1'b1, pq13, pq13};
									5'd11: mul_req_q <= '{1'b1, mp, p9};
									default: mul_req_q <= '{1'b1, p8, r0_q};
								endcase
							end
							5'd8: begin
								if (pv1 == '0) begin
									state_q <= ST_OUT;
								end else begin
									mul_req_q <= '{1'b1, pnum, 64'd3125};
									state_q   <= ST_MUL;
								end
							end
							5'd9: begin
								div_req_q <= '{1'b1, mp, r1_q};
								state_q   <= ST_DIV;
							end
							5'd16: begin
								state_q <= ST_OUT;
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; the sequencer above owns the control flow.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			kind_q <= opcode;
			adc_q  <= raw_sample;
		end
		if (state_q == ST_OUT && (!out_valid_q || !out_stall)) begin
			out_kind_q  <= kind_q;
			out_temp_q  <= res_temp_q;
			out_press_q <= res_press_q;
			out_zero_q  <= res_zero_q;
		end
		if (state_q == ST_CALC) begin
			if (kind_q == OpTemp) begin
				case (step_q)
					5'd1: r0_q <= sx32(32'($signed(mp[31:0]) >>> 11));
					5'd4: begin
						res_temp_q  <= tres;
						res_press_q <= '0;
						res_zero_q  <= 1'b0;
					end
					default: begin
					end
				endcase
			end else begin
				case (step_q)
					5'd0: r0_q <= pden;
					5'd1: r1_q <= mp;
					5'd2: r2_q <= mp;
					5'd3: r2_q <= r2_q + (mp << 17);
					5'd4: r2_q <= r2_q + (p4 << 35);
					5'd5: r1_q <= 64'($signed(mp) >>> 8);
					5'd6: r1_q <= r1_q + (mp << 12);
					5'd8: begin
						r1_q        <= pv1;
						res_temp_q  <= '0;
						res_press_q <= '0;
						res_zero_q  <= (pv1 == '0);
					end
					5'd10: r0_q <= dq;
					5'd12: r1_q <= 64'($signed(mp) >>> 25);
					5'd13: r2_q <= 64'($signed(mp) >>> 19);
					5'd14: r0_q <= r0_q + r1_q;
					5'd15: r0_q <= r0_q + r2_q;
					5'd16: res_press_q <= 32'(64'($signed(r0_q) >>> 8) + (p7 << 4));
					default: begin
					end
				endcase
			end
		end
	end

	assign in_stall          = (state_q != ST_IDLE);
	assign out_valid         = out_valid_q;
	assign result_kind       = out_kind_q;
	assign temperature_centi = out_temp_q;
	assign pressure_q24_8    = out_press_q;
	assign zero_divisor      = out_zero_q;
endmodule
`default_nettype wire

// File: src/bpc_mul.sv
// Bit-serial 64 x 64 multiplier keeping the low 64 bits of the product.
// One multiplier bit per cycle; depends on bpc_pkg.
`default_nettype none
module bpc_mul
	import bpc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire op_req_t           req,
	output logic                   done,
	output logic [WordW-1:0]       prod
);
	logic [WordW-1:0] acc_q, mc_q, mp_q;
	logic [6:0]       cnt_q;
	logic             done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= 7'(WordW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			mc_q  <= req.a;
			mp_q  <= req.b;
		end else if (cnt_q != '0) begin
			if (mp_q[0]) begin
				acc_q <= acc_q + mc_q;
			end
			mc_q <= {mc_q[WordW-2:0], 1'b0};
			mp_q <= {1'b0, mp_q[WordW-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule
`default_nettype wire

// File: src/bpc_div.sv
// Restoring signed 64-bit divider, one quotient bit per cycle, truncating
// toward zero. The divisor must be nonzero. Depends on bpc_pkg.
`default_nettype none
module bpc_div
	import bpc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire op_req_t           req,
	output logic                   done,
	output logic [WordW-1:0]       quo
);
	logic [WordW:0]   rem_q;
	logic [WordW-1:0] q_q, den_q;
	logic             neg_q;
	logic [6:0]       cnt_q;
	logic             done_q;
	logic [WordW:0]   shifted, diff;

	assign shifted = {rem_q[WordW-1:0], q_q[WordW-1]};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= 7'(WordW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			q_q   <= req.a[WordW-1] ? (WordW'(0) - req.a) : req.a;
			den_q <= req.b[WordW-1] ? (WordW'(0) - req.b) : req.b;
			neg_q <= req.a[WordW-1] ^ req.b[WordW-1];
		end else if (cnt_q != '0) begin
			if (!diff[WordW]) begin
				rem_q <= diff;
				q_q   <= {q_q[WordW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				q_q   <= {q_q[WordW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? (WordW'(0) - q_q) : q_q;
endmodule
`default_nettype wire

// File: tb/sv/baro_comp_checker.sv
// Checker for the pressure compensation core: watches the config, input and
// output channels, predicts each result and compares it. Depends on bpc_pkg.
`timescale 1ns / 1ps
module baro_comp_checker
	import bpc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire logic               opcode,
	input  wire logic [19:0]        raw_sample,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic               result_kind,
	input  wire logic [31:0]        temperature_centi,
	input  wire logic [31:0]        pressure_q24_8,
	input  wire logic               zero_divisor,
	input  wire logic               cfg_valid,
	input  wire logic               cfg_ready,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [31:0]        cfg_data,
	output int                      fail_count,
	output int                      pending
);
	typedef struct packed {
		logic        kind;
		logic [31:0] temp;
		logic [31:0] press;
		logic        zero;
	} comp_result_t;

	logic [31:0] cal_word [NumRegs];
	logic [31:0] fine_t;
	comp_result_t expected_results[$];

	assign pending = expected_results.size();

	function automatic logic [63:0] cal_half(input int r, input bit hi);
		return sx16(hi ? cal_word[r][31:16] : cal_word[r][15:0]);
	endfunction

	task automatic compensate(input logic op, input logic [19:0] adc);
		comp_result_t r;
		logic signed [31:0] t1, t2, t3, a, b, v1s, v2s;
		logic signed [63:0] v1, v2, p, h, p1, num, den;
		logic [63:0] ua, ub, q;
		r = '0;
		r.kind = op;
		if (op == OpTemp) begin
			t1 = {16'd0, cal_word[RegT1][15:0]};
			t2 = sx16(cal_word[RegT2][15:0]);
			t3 = sx16(cal_word[RegT3][15:0]);
			a = {12'd0, adc} >>> 3;
			a = a - (t1 <<< 1);
			v1s = (a * t2) >>> 11;
			b = ({12'd0, adc} >>> 4) - t1;
			v2s = (((b * b) >>> 12) * t3) >>> 14;
			fine_t = v1s + v2s;
			r.temp = ($signed(fine_t) * 5 + 128) >>> 8;
		end else begin
			p1 = {48'd0, cal_word[RegP1][15:0]};
			v1 = sx32(fine_t) - 64'sd128000;
			v2 = v1 * v1 * $signed(cal_half(RegP67, 0));
			v2 = v2 + ((v1 * $signed(cal_half(RegP45, 1))) <<< 17);
			v2 = v2 + ($signed(cal_half(RegP45, 0)) <<< 35);
			v1 = ((v1 * v1 * $signed(cal_half(RegP23, 1))) >>> 8)
				+ ((v1 * $signed(cal_half(RegP23, 0))) <<< 12);
			v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
			if (v1 == 0) begin
				r.zero = 1'b1;
			end else begin
				p = 64'sd1048576 - {44'd0, adc};
				num = ((p <<< 31) - v2) * 64'sd3125;
				den = v1;
				ua = num[63] ? -num : num;
				ub = den[63] ? -den : den;
				q = ua / ub;
				p = (num[63] != den[63]) ? -q : q;
				h = p >>> 13;
				v1 = ($signed(cal_half(RegP89, 1)) * h * h) >>> 25;
				v2 = ($signed(cal_half(RegP89, 0)) * p) >>> 19;
				p = ((p + v1 + v2) >>> 8) + ($signed(cal_half(RegP67, 1)) <<< 4);
				r.press = p[31:0];
			end
		end
		expected_results.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		comp_result_t e;
		if (!arst_n) begin
			for (int i = 0; i < NumRegs; i++) cal_word[i] = '0;
			fine_t = '0;
			fail_count = 0;
			expected_results.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result beat: kind %0d", result_kind);
				end else begin
					e = expected_results.pop_front();
					if (e.kind !== result_kind || e.temp !== temperature_centi
							|| e.press !== pressure_q24_8 || e.zero !== zero_divisor) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: exp kind %0d t %0d p %h z %0d, got %0d %0d %h %0d",
								e.kind, $signed(e.temp), e.press, e.zero, result_kind,
								$signed(temperature_centi), pressure_q24_8, zero_divisor);
					end
				end
			end
			if (in_valid && !in_stall)
				compensate(opcode, raw_sample);
			if (cfg_valid && cfg_ready && cfg_index < NumRegs)
				cal_word[cfg_index] = (cfg_index <= RegP1) ? {16'd0, cfg_data[15:0]} : cfg_data;
		end
	end
endmodule

// File: tb/sv/baro_temp_pressure_compensation_core_test.sv
// Top of the compensation core testbench: clock, reset, calibration phases,
// sample stimulus and verdict. Depends on bpc_pkg, the core and baro_comp_checker.
`timescale 1ns / 1ps
module baro_temp_pressure_compensation_core_test;
	import bpc_pkg::*;

	logic clk = 1'b0, arst_n = 1'b0;
	logic in_valid = 1'b0, opcode = 1'b0, out_stall = 1'b0, cfg_valid = 1'b0;
	logic [19:0] raw_sample = '0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_stall, out_valid, result_kind, zero_divisor, cfg_ready;
	logic [31:0] temperature_centi, pressure_q24_8;
	int fail_count, pending;
	bit hold_off = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	baro_temp_pressure_compensation_core u_dut (.*);
	baro_comp_checker u_check (.*);

	// Receiver stall pattern, with one long hold-off on request.
	always @(posedge clk) begin
		if (hold_off)
			out_stall <= 1'b1;
		else
			out_stall <= ($urandom_range(0, 3) == 0);
	end

	// One register write; the channel goes idle after each beat.
	task automatic write_cal(input logic [CfgIdxW-1:0] idx, input logic [31:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained;
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (1000) @(posedge clk);
	endtask

	// Sends one sample beat; a random gap follows at the end of a burst.
	task automatic send_sample(input logic op, input logic [19:0] adc);
		in_valid <= 1'b1;
		opcode <= op;
		raw_sample <= adc;
		do @(posedge clk); while (in_stall);
		if ($urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
	endtask

	task automatic load_cal(input int mode);
		for (int r = 0; r < NumRegs; r++) begin
			case (mode)
				0: write_cal(CfgIdxW'(r), 32'd0);
				1: write_cal(CfgIdxW'(r), 32'hffffffff);
				2: write_cal(CfgIdxW'(r), (r <= int'(RegP1)) ? 32'h00008000 : 32'h80008000);
				default: write_cal(CfgIdxW'(r), $urandom);
			endcase
		end
	endtask

	task automatic load_typical;
		write_cal(RegT1, 27504); write_cal(RegT2, 26435); write_cal(RegT3, 32'h0000fc18);
		write_cal(RegP1, 36477);
		write_cal(RegP23, {16'd3024, 16'hd6d0});
		write_cal(RegP45, {16'hff73, 16'd2855});
		write_cal(RegP67, {16'd15500, 16'hfff9});
		write_cal(RegP89, {16'd6000, 16'hc4a4});
		write_cal(CfgIdxW'(NumRegs), 32'h0);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Pressure before any temperature, with zero divisor at reset values.
		send_sample(OpPress, 20'd0);
		send_sample(OpTemp, 20'hfffff);
		wait_drained();
		load_typical();
		send_sample(OpPress, 20'd415148);
		send_sample(OpTemp, 20'd519888);
		send_sample(OpPress, 20'd415148);
		send_sample(OpTemp, 20'd0);
		send_sample(OpPress, 20'hfffff);
		send_sample(OpPress, 20'd0);
		wait_drained();
		for (int m = 0; m < 3; m++) begin
			load_cal(m);
			send_sample(OpTemp, 20'hfffff);
			send_sample(OpPress, 20'd0);
			send_sample(OpTemp, 20'd0);
			send_sample(OpPress, 20'hfffff);
			wait_drained();
		end
		for (int ph = 0; ph < 6; ph++) begin
			if (ph < 3) load_typical(); else load_cal(3);
			if (ph == 1) begin
				fork
					begin
						hold_off = 1'b1;
						repeat (4000) @(posedge clk);
						hold_off = 1'b0;
					end
				join_none
			end
			for (int i = 0; i < 90; i++)
				send_sample(1'($urandom_range(0, 1)), (ph < 3 && i % 4 != 0)
					? 20'($urandom_range(300000, 600000)) : 20'($urandom));
			wait_drained();
		end
		write_cal(8'd200, $urandom);
		wait_drained();
		if (fail_count == 0)
			$display("baro_temp_pressure_compensation_core test passed");
		else
			$display("baro_temp_pressure_compensation_core test failed");
		$finish;
	end

	initial begin
		#40ms;
		$display("baro_temp_pressure_compensation_core test failed");
		$finish;
	end
endmodule

// File: baro_temp_pressure_compensation_core.f
src/bpc_pkg.sv
src/bpc_mul.sv
src/bpc_div.sv
src/baro_temp_pressure_compensation_core.sv
tb/sv/baro_comp_checker.sv
tb/sv/baro_temp_pressure_compensation_core_test.sv
